@@ rtl/sgr_pkg.sv @@
package sgr_pkg;

   localparam int unsigned GlyphCols = 5;
   localparam int unsigned GlyphRows = 7;
   localparam int unsigned GlyphSlots = 43;

   localparam logic [1:0] StatusOk = 2'd0;
   localparam logic [1:0] StatusNotReady = 2'd1;
   localparam logic [1:0] StatusParamError = 2'd2;

   localparam logic KindRect = 1'b0;
   localparam logic KindStatus = 1'b1;

   localparam logic [5:0] SlotLetters = 6'd10;
   localparam logic [5:0] SlotDash = 6'd36;
   localparam logic [5:0] SlotColon = 6'd37;
   localparam logic [5:0] SlotSlash = 6'd38;
   localparam logic [5:0] SlotDot = 6'd39;
   localparam logic [5:0] SlotPercent = 6'd40;
   localparam logic [5:0] SlotDegree = 6'd41;
   localparam logic [5:0] SlotBlank = 6'd42;

   localparam logic [7:0] CodeDegree = 8'hB0;

   typedef logic [0:GlyphCols-1][7:0] glyph_type;
   typedef logic [GlyphCols-1:0][GlyphRows-1:0] dot_mask_type;

   localparam glyph_type FontRom [0:GlyphSlots-1] = '{
      '{8'h3E, 8'h51, 8'h49, 8'h45, 8'h3E}, '{8'h00, 8'h42, 8'h7F, 8'h40, 8'h00},
      '{8'h42, 8'h61, 8'h51, 8'h49, 8'h46}, '{8'h21, 8'h41, 8'h45, 8'h4B, 8'h31},
      '{8'h18, 8'h14, 8'h12, 8'h7F, 8'h10}, '{8'h27, 8'h45, 8'h45, 8'h45, 8'h39},
      '{8'h3C, 8'h4A, 8'h49, 8'h49, 8'h30}, '{8'h01, 8'h71, 8'h09, 8'h05, 8'h03},
      '{8'h36, 8'h49, 8'h49, 8'h49, 8'h36}, '{8'h06, 8'h49, 8'h49, 8'h29, 8'h1E},
      '{8'h7E, 8'h11, 8'h11, 8'h11, 8'h7E}, '{8'h7F, 8'h49, 8'h49, 8'h49, 8'h36},
      '{8'h3E, 8'h41, 8'h41, 8'h41, 8'h22}, '{8'h7F, 8'h41, 8'h41, 8'h22, 8'h1C},
      '{8'h7F, 8'h49, 8'h49, 8'h49, 8'h41}, '{8'h7F, 8'h09, 8'h09, 8'h09, 8'h01},
      '{8'h3E, 8'h41, 8'h49, 8'h49, 8'h7A}, '{8'h7F, 8'h08, 8'h08, 8'h08, 8'h7F},
      '{8'h00, 8'h41, 8'h7F, 8'h41, 8'h00}, '{8'h20, 8'h40, 8'h41, 8'h3F, 8'h01},
      '{8'h7F, 8'h08, 8'h14, 8'h22, 8'h41}, '{8'h7F, 8'h40, 8'h40, 8'h40, 8'h40},
      '{8'h7F, 8'h02, 8'h0C, 8'h02, 8'h7F}, '{8'h7F, 8'h04, 8'h08, 8'h10, 8'h7F},
      '{8'h3E, 8'h41, 8'h41, 8'h41, 8'h3E}, '{8'h7F, 8'h09, 8'h09, 8'h09, 8'h06},
      '{8'h3E, 8'h41, 8'h51, 8'h21, 8'h5E}, '{8'h7F, 8'h09, 8'h19, 8'h29, 8'h46},
      '{8'h46, 8'h49, 8'h49, 8'h49, 8'h31}, '{8'h01, 8'h01, 8'h7F, 8'h01, 8'h01},
      '{8'h3F, 8'h40, 8'h40, 8'h40, 8'h3F}, '{8'h1F, 8'h20, 8'h40, 8'h20, 8'h1F},
      '{8'h7F, 8'h20, 8'h18, 8'h20, 8'h7F}, '{8'h63, 8'h14, 8'h08, 8'h14, 8'h63},
      '{8'h07, 8'h08, 8'h70, 8'h08, 8'h07}, '{8'h61, 8'h51, 8'h49, 8'h45, 8'h43},
      '{8'h08, 8'h08, 8'h08, 8'h08, 8'h08}, '{8'h00, 8'h36, 8'h36, 8'h00, 8'h00},
      '{8'h20, 8'h10, 8'h08, 8'h04, 8'h02}, '{8'h00, 8'h60, 8'h60, 8'h00, 8'h00},
      '{8'h23, 8'h13, 8'h08, 8'h64, 8'h62}, '{8'h02, 8'h05, 8'h02, 8'h00, 8'h00},
      '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
   };

   typedef struct packed {
      logic [15:0] origin_x;
      logic [15:0] origin_y;
      logic [7:0]  char_code;
      logic [15:0] pixel_color;
      logic [7:0]  scale_factor;
   } req_type;

   typedef struct packed {
      logic        item_kind;
      logic [1:0]  status;
      logic [11:0] rect_x;
      logic [11:0] rect_y;
      logic [7:0]  rect_side;
      logic [15:0] rect_color;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic [11:0]  origin_x;
      logic [11:0]  origin_y;
      logic [15:0]  pixel_color;
      logic [7:0]   scale_factor;
      logic [1:0]   status;
      dot_mask_type dots;
   } cmd_type;

   function automatic logic [5:0] glyph_slot(input logic [7:0] code);
      logic [7:0] up;
      logic [5:0] slot;
      up = code;
      if (code >= 8'h61 && code <= 8'h7A) begin
         up = code - 8'h20;
      end
      priority if (code >= 8'h30 && code <= 8'h39) begin
         slot = 6'(code - 8'h30);
      end else if (up >= 8'h41 && up <= 8'h5A) begin
         slot = SlotLetters + 6'(up - 8'h41);
      end else if (code == 8'h2D) begin
         slot = SlotDash;
      end else if (code == 8'h3A) begin
         slot = SlotColon;
      end else if (code == 8'h2F) begin
         slot = SlotSlash;
      end else if (code == 8'h2E) begin
         slot = SlotDot;
      end else if (code == 8'h25) begin
         slot = SlotPercent;
      end else if (code == CodeDegree) begin
         slot = SlotDegree;
      end else begin
         slot = SlotBlank;
      end
      return slot;
   endfunction

   function automatic dot_mask_type glyph_dots(input logic [7:0] code);
      glyph_type    g;
      dot_mask_type m;
      g = FontRom[glyph_slot(code)];
      for (int c = 0; c < GlyphCols; c++) begin
         m[c] = g[c][GlyphRows-1:0];
      end
      return m;
   endfunction

endpackage

@@ rtl/scaled_glyph_renderer.sv @@
// A character's first result reaches the result ports through the front command queue,
// the back end's command register and result queue. Results come one per cycle while
// the result queue has room; the back end walks the dot mask, one rectangle per set dot.
// A two-entry command queue and a two-entry result queue hold transactions on stalls.
// Reset: synchronous, active high; empties both queues and clears display_ready.
module scaled_glyph_renderer #(
   parameter int unsigned SCREEN_WIDTH = 320,
   parameter int unsigned SCREEN_HEIGHT = 240
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   output logic             req_full,
   input  sgr_pkg::req_type req_data,
   output logic             rsp_empty,
   input  logic             rsp_pop,
   output sgr_pkg::rsp_type rsp_data,
   input  logic             csr_we,
   input  logic             csr_wdata
);

   logic             cmd_valid;
   logic             cmd_take;
   sgr_pkg::cmd_type cmd_data;

   sgr_front #(
      .SCREEN_WIDTH (SCREEN_WIDTH),
      .SCREEN_HEIGHT(SCREEN_HEIGHT)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_full (req_full),
      .req_data (req_data),
      .csr_we   (csr_we),
      .csr_wdata(csr_wdata),
      .cmd_valid(cmd_valid),
      .cmd_take (cmd_take),
      .cmd_data (cmd_data)
   );

   sgr_back u_back (
      .clock    (clock),
      .reset    (reset),
      .cmd_valid(cmd_valid),
      .cmd_take (cmd_take),
      .cmd_data (cmd_data),
      .rsp_empty(rsp_empty),
      .rsp_pop  (rsp_pop),
      .rsp_data (rsp_data)
   );

endmodule

@@ rtl/sgr_front.sv @@
module sgr_front #(
   parameter int unsigned SCREEN_WIDTH = 320,
   parameter int unsigned SCREEN_HEIGHT = 240
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   output logic             req_full,
   input  sgr_pkg::req_type req_data,
   input  logic             csr_we,
   input  logic             csr_wdata,
   output logic             cmd_valid,
   input  logic             cmd_take,
   output sgr_pkg::cmd_type cmd_data
);

   logic             display_ready_ff;
   sgr_pkg::cmd_type queue_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       count_ff, count_in;
   logic             push_ok;
   logic             pop_ok;
   logic [16:0]      right_edge;
   logic [16:0]      bottom_edge;
   sgr_pkg::cmd_type classified;

   assign req_full  = (count_ff == 2'd2);
   assign cmd_valid = (count_ff != 2'd0);
   assign cmd_data  = queue_ff[rd_ptr_ff];
   assign push_ok   = req_push && !req_full;
   assign pop_ok    = cmd_take && cmd_valid;

   always_comb begin
      right_edge  = {1'b0, req_data.origin_x} + 17'(req_data.scale_factor) * 17'd5;
      bottom_edge = {1'b0, req_data.origin_y} + 17'(req_data.scale_factor) * 17'd7;
      classified.origin_x     = req_data.origin_x[11:0];
      classified.origin_y     = req_data.origin_y[11:0];
      classified.pixel_color  = req_data.pixel_color;
      classified.scale_factor = req_data.scale_factor;
      classified.dots         = sgr_pkg::glyph_dots(req_data.char_code);
      priority if (!display_ready_ff) begin
         classified.status = sgr_pkg::StatusNotReady;
         classified.dots   = '0;
      end else if (req_data.scale_factor == 8'd0 ||
                   right_edge > 17'(SCREEN_WIDTH) ||
                   bottom_edge > 17'(SCREEN_HEIGHT)) begin
         classified.status = sgr_pkg::StatusParamError;
         classified.dots   = '0;
      end else begin
         classified.status = sgr_pkg::StatusOk;
      end
   end

   always_comb begin
      wr_ptr_in = push_ok ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop_ok ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push_ok) - 2'(pop_ok);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         display_ready_ff <= 1'b0;
         wr_ptr_ff        <= 1'b0;
         rd_ptr_ff        <= 1'b0;
         count_ff         <= 2'd0;
      end else begin
         if (csr_we) begin
            display_ready_ff <= csr_wdata;
         end
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         queue_ff[wr_ptr_ff] <= classified;
      end
   end

endmodule

@@ rtl/sgr_back.sv @@
module sgr_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             cmd_valid,
   output logic             cmd_take,
   input  sgr_pkg::cmd_type cmd_data,
   output logic             rsp_empty,
   input  logic             rsp_pop,
   output sgr_pkg::rsp_type rsp_data
);

   logic                  busy_ff, busy_in;
   sgr_pkg::cmd_type      cmd_ff;
   sgr_pkg::dot_mask_type dots_ff, dots_in;
   logic                  load;
   logic                  emit;
   logic                  can_emit;
   logic [2:0]            hit_col;
   logic [2:0]            hit_row;
   logic [6:0]            col_bits;
   logic [10:0]           col_offset;
   logic [10:0]           row_offset;
   sgr_pkg::rsp_type      item;

   sgr_pkg::rsp_type      out_ff [2];
   logic                  out_wr_ff;
   logic                  out_rd_ff;
   logic [1:0]            out_count_ff;
   logic                  out_pop;

   assign rsp_empty = (out_count_ff == 2'd0);
   assign rsp_data  = out_ff[out_rd_ff];
   assign out_pop   = rsp_pop && !rsp_empty;
   assign can_emit  = (out_count_ff != 2'd2) || out_pop;
   assign emit      = busy_ff && can_emit;

   always_comb begin
      hit_col = 3'd0;
      for (int c = sgr_pkg::GlyphCols - 1; c >= 0; c--) begin
         if (|dots_ff[c]) begin
            hit_col = 3'(c);
         end
      end
      col_bits = dots_ff[hit_col];
      hit_row  = 3'd0;
      for (int r = sgr_pkg::GlyphRows - 1; r >= 0; r--) begin
         if (col_bits[r]) begin
            hit_row = 3'(r);
         end
      end
      col_offset = 11'(hit_col) * 11'(cmd_ff.scale_factor);
      row_offset = 11'(hit_row) * 11'(cmd_ff.scale_factor);
   end

   always_comb begin
      item    = '0;
      dots_in = dots_ff;
      busy_in = busy_ff;
      load    = 1'b0;
      if (!busy_ff) begin
         load = cmd_valid;
      end else if (emit) begin
         if (dots_ff != '0) begin
            item.item_kind  = sgr_pkg::KindRect;
            item.status     = sgr_pkg::StatusOk;
            item.rect_x     = cmd_ff.origin_x + 12'(col_offset);
            item.rect_y     = cmd_ff.origin_y + 12'(row_offset);
            item.rect_side  = cmd_ff.scale_factor;
            item.rect_color = cmd_ff.pixel_color;
            item.last       = 1'b0;
            dots_in[hit_col][hit_row] = 1'b0;
         end else begin
            item.item_kind = sgr_pkg::KindStatus;
            item.status    = cmd_ff.status;
            item.last      = 1'b1;
            load           = cmd_valid;
         end
      end
      if (load) begin
         busy_in = 1'b1;
         dots_in = cmd_data.dots;
      end else if (emit && dots_ff == '0) begin
         busy_in = 1'b0;
      end
   end

   assign cmd_take = load;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         out_wr_ff    <= 1'b0;
         out_rd_ff    <= 1'b0;
         out_count_ff <= 2'd0;
      end else begin
         busy_ff <= busy_in;
         if (emit) begin
            out_wr_ff <= !out_wr_ff;
         end
         if (out_pop) begin
            out_rd_ff <= !out_rd_ff;
         end
         out_count_ff <= out_count_ff + 2'(emit) - 2'(out_pop);
      end
   end

   always_ff @(posedge clock) begin
      dots_ff <= dots_in;
      if (load) begin
         cmd_ff <= cmd_data;
      end
      if (emit) begin
         out_ff[out_wr_ff] <= item;
      end
   end

endmodule

@@ tb/tb_scaled_glyph_renderer.sv @@
`timescale 1ns / 100ps

module tb_scaled_glyph_renderer;

   localparam int unsigned SCREEN_W = 320;
   localparam int unsigned SCREEN_H = 240;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int HOLD_CYCLES = 400;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_push = 1'b0;
   logic             req_full;
   sgr_pkg::req_type req_data = '0;
   logic             rsp_empty;
   logic             rsp_pop = 1'b0;
   sgr_pkg::rsp_type rsp_data;
   logic             csr_we = 1'b0;
   logic             csr_wdata = 1'b0;

   logic             model_ready = 1'b0;
   logic             hold_off = 1'b0;
   int               send_idle_pct = 0;
   int               pop_stall_pct = 0;
   int               quiet_cycles = 0;
   int               mismatches = 0;
   int               chars_sent = 0;
   int               rects_seen = 0;
   int               status_seen = 0;
   int               not_ready_seen = 0;
   int               param_errors_seen = 0;
   sgr_pkg::rsp_type due_items[$];
   string glyph_chars = "0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz-:/.%";
   event             start_hold;

   scaled_glyph_renderer #(
      .SCREEN_WIDTH(SCREEN_W),
      .SCREEN_HEIGHT(SCREEN_H)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_push(req_push),
      .req_full(req_full),
      .req_data(req_data),
      .rsp_empty(rsp_empty),
      .rsp_pop(rsp_pop),
      .rsp_data(rsp_data),
      .csr_we(csr_we),
      .csr_wdata(csr_wdata)
   );

   always #5 clock = ~clock;

   // column bytes, leftmost column in the top byte; bit r of a byte is row r
   function automatic logic [39:0] font_columns(input logic [7:0] code);
      logic [7:0] folded;
      folded = code;
      if (code >= "a" && code <= "z") begin
         folded = code - 8'h20;
      end
      case (folded)
         "0": return 40'h3E5149453E;
         "1": return 40'h00427F4000;
         "2": return 40'h4261514946;
         "3": return 40'h2141454B31;
         "4": return 40'h1814127F10;
         "5": return 40'h2745454539;
         "6": return 40'h3C4A494930;
         "7": return 40'h0171090503;
         "8": return 40'h3649494936;
         "9": return 40'h064949291E;
         "A": return 40'h7E1111117E;
         "B": return 40'h7F49494936;
         "C": return 40'h3E41414122;
         "D": return 40'h7F4141221C;
         "E": return 40'h7F49494941;
         "F": return 40'h7F09090901;
         "G": return 40'h3E4149497A;
         "H": return 40'h7F0808087F;
         "I": return 40'h00417F4100;
         "J": return 40'h2040413F01;
         "K": return 40'h7F08142241;
         "L": return 40'h7F40404040;
         "M": return 40'h7F020C027F;
         "N": return 40'h7F0408107F;
         "O": return 40'h3E4141413E;
         "P": return 40'h7F09090906;
         "Q": return 40'h3E4151215E;
         "R": return 40'h7F09192946;
         "S": return 40'h4649494931;
         "T": return 40'h01017F0101;
         "U": return 40'h3F4040403F;
         "V": return 40'h1F2040201F;
         "W": return 40'h7F2018207F;
         "X": return 40'h6314081463;
         "Y": return 40'h0708700807;
         "Z": return 40'h6151494543;
         "-": return 40'h0808080808;
         ":": return 40'h0036360000;
         "/": return 40'h2010080402;
         ".": return 40'h0060600000;
         "%": return 40'h2313086462;
         sgr_pkg::CodeDegree: return 40'h0205020000;
         default: return 40'h0;
      endcase
   endfunction

   function automatic void predict_glyph(input sgr_pkg::req_type cmd);
      logic [39:0]      cols;
      sgr_pkg::rsp_type item;
      int unsigned      side;
      side = cmd.scale_factor;
      item = '0;
      if (!model_ready) begin
         item.status = sgr_pkg::StatusNotReady;
      end else if (side == 0 || cmd.origin_x + sgr_pkg::GlyphCols * side > SCREEN_W ||
                   cmd.origin_y + sgr_pkg::GlyphRows * side > SCREEN_H) begin
         item.status = sgr_pkg::StatusParamError;
      end else begin
         cols = font_columns(cmd.char_code);
         for (int c = 0; c < sgr_pkg::GlyphCols; c++) begin
            for (int r = 0; r < sgr_pkg::GlyphRows; r++) begin
               if (cols[8 * (sgr_pkg::GlyphCols - 1 - c) + r]) begin
                  item = '0;
                  item.item_kind = sgr_pkg::KindRect;
                  item.status = sgr_pkg::StatusOk;
                  item.rect_x = 12'(cmd.origin_x + c * side);
                  item.rect_y = 12'(cmd.origin_y + r * side);
                  item.rect_side = cmd.scale_factor;
                  item.rect_color = cmd.pixel_color;
                  due_items.push_back(item);
               end
            end
         end
         item = '0;
         item.status = sgr_pkg::StatusOk;
      end
      item.item_kind = sgr_pkg::KindStatus;
      item.last = 1'b1;
      due_items.push_back(item);
   endfunction

   function automatic void compare_field(input string name, input int unsigned want,
                                         input int unsigned got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
         mismatches++;
      end
   endfunction

   task automatic match_draw_item(input sgr_pkg::rsp_type got);
      sgr_pkg::rsp_type want;
      if (due_items.size() == 0) begin
         $display("%0t: unexpected transaction, got kind %0d status %0d", $time,
                  got.item_kind, got.status);
         mismatches++;
      end else begin
         want = due_items.pop_front();
         compare_field("item_kind", want.item_kind, got.item_kind);
         compare_field("status", want.status, got.status);
         compare_field("rect_x", want.rect_x, got.rect_x);
         compare_field("rect_y", want.rect_y, got.rect_y);
         compare_field("rect_side", want.rect_side, got.rect_side);
         compare_field("rect_color", want.rect_color, got.rect_color);
         compare_field("last", want.last, got.last);
         if (want.item_kind == sgr_pkg::KindRect) begin
            rects_seen++;
         end else begin
            status_seen++;
            if (want.status == sgr_pkg::StatusNotReady) not_ready_seen++;
            if (want.status == sgr_pkg::StatusParamError) param_errors_seen++;
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         if (rsp_pop && !rsp_empty) match_draw_item(rsp_data);
         rsp_pop <= !hold_off && ($urandom_range(99) >= pop_stall_pct);
      end
   end

   always begin
      @(start_hold);
      hold_off <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_off <= 1'b0;
   end

   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no transaction for %0d cycles", $time, quiet_cycles);
         $display("FAIL scaled_glyph_renderer");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_char(input sgr_pkg::req_type cmd);
      while ($urandom_range(99) < send_idle_pct) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push <= 1'b1;
      req_data <= cmd;
      @(posedge clock);
      while (req_full) @(posedge clock);
      predict_glyph(cmd);
      chars_sent++;
   endtask

   task automatic drain_results();
      req_push <= 1'b0;
      while (due_items.size() != 0) @(posedge clock);
   endtask

   task automatic set_display_ready(input logic ready);
      csr_we <= 1'b1;
      csr_wdata <= ready;
      @(posedge clock);
      csr_we <= 1'b0;
      model_ready = ready;
   endtask

   function automatic sgr_pkg::req_type glyph_at(input int unsigned x, input int unsigned y,
                                                 input logic [7:0] code,
                                                 input logic [15:0] color,
                                                 input logic [7:0] side);
      sgr_pkg::req_type cmd;
      cmd.origin_x = 16'(x);
      cmd.origin_y = 16'(y);
      cmd.char_code = code;
      cmd.pixel_color = color;
      cmd.scale_factor = side;
      return cmd;
   endfunction

   function automatic sgr_pkg::req_type random_char();
      sgr_pkg::req_type cmd;
      int unsigned      side;
      cmd.pixel_color = 16'($urandom);
      if ($urandom_range(99) < 80) begin
         side = ($urandom_range(9) == 0) ? $urandom_range(1, 34) : $urandom_range(1, 4);
         cmd.scale_factor = 8'(side);
         cmd.origin_x = 16'($urandom_range(SCREEN_W - sgr_pkg::GlyphCols * side));
         cmd.origin_y = 16'($urandom_range(SCREEN_H - sgr_pkg::GlyphRows * side));
         if ($urandom_range(15) == 0) begin
            cmd.char_code = sgr_pkg::CodeDegree;
         end else begin
            cmd.char_code = glyph_chars[$urandom_range(glyph_chars.len() - 1)];
         end
      end else begin
         cmd.origin_x = $urandom_range(1) ? 16'($urandom) : 16'($urandom_range(SCREEN_W));
         cmd.origin_y = $urandom_range(1) ? 16'($urandom) : 16'($urandom_range(SCREEN_H));
         cmd.char_code = 8'($urandom);
         case ($urandom_range(2))
            0: cmd.scale_factor = 8'd0;
            1: cmd.scale_factor = 8'($urandom_range(1, 8));
            default: cmd.scale_factor = 8'($urandom);
         endcase
      end
      return cmd;
   endfunction

   task automatic test_not_ready_after_reset();
      send_char(glyph_at(0, 0, "0", 16'hFFFF, 8'd1));
      send_char(glyph_at(65535, 65535, 8'hFF, 16'h0000, 8'd0));
      drain_results();
   endtask

   task automatic test_glyph_set();
      set_display_ready(1'b1);
      send_char(glyph_at(0, 0, "0", 16'hFFFF, 8'd1));
      send_char(glyph_at(315, 233, "8", 16'h0000, 8'd1));
      send_char(glyph_at(10, 20, "A", 16'hF800, 8'd2));
      send_char(glyph_at(100, 100, "z", 16'h07E0, 8'd3));
      send_char(glyph_at(50, 60, "a", 16'h001F, 8'd1));
      send_char(glyph_at(7, 9, "9", 16'h5555, 8'd4));
      send_char(glyph_at(1, 2, "-", 16'hAAAA, 8'd1));
      send_char(glyph_at(3, 4, ":", 16'h1234, 8'd2));
      send_char(glyph_at(5, 6, "/", 16'h8001, 8'd1));
      send_char(glyph_at(8, 8, ".", 16'h7FFE, 8'd1));
      send_char(glyph_at(200, 100, "%", 16'hC3C3, 8'd5));
      send_char(glyph_at(300, 200, sgr_pkg::CodeDegree, 16'h3C3C, 8'd2));
      send_char(glyph_at(20, 20, 8'h00, 16'hFFFF, 8'd1));
      send_char(glyph_at(20, 20, 8'hFF, 16'hFFFF, 8'd1));
      send_char(glyph_at(0, 0, "W", 16'hFFFF, 8'd34));
      drain_results();
   endtask

   task automatic test_parameter_errors();
      send_char(glyph_at(0, 0, "E", 16'hFFFF, 8'd0));
      send_char(glyph_at(316, 0, "E", 16'hFFFF, 8'd1));
      send_char(glyph_at(0, 234, "E", 16'hFFFF, 8'd1));
      send_char(glyph_at(0, 0, "E", 16'hFFFF, 8'd255));
      send_char(glyph_at(65535, 65535, "E", 16'hFFFF, 8'd1));
      send_char(glyph_at(150, 2, "M", 16'h0F0F, 8'd34));
      drain_results();
   endtask

   task automatic test_backpressure();
      send_idle_pct = 0;
      pop_stall_pct = 0;
      -> start_hold;
      repeat (14) send_char(random_char());
      drain_results();
   endtask

   task automatic run_random_phase(input int count, input int idle_pct, input int stall_pct);
      send_idle_pct = idle_pct;
      pop_stall_pct = stall_pct;
      repeat (count) send_char(random_char());
      drain_results();
   endtask

   task automatic test_random_traffic();
      run_random_phase(100, 0, 0);
      run_random_phase(100, 58, 0);
      run_random_phase(100, 0, 58);
      set_display_ready(1'b0);
      run_random_phase(30, 19, 19);
      set_display_ready(1'b1);
      run_random_phase(70, 19, 19);
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_not_ready_after_reset();
      test_glyph_set();
      test_parameter_errors();
      test_backpressure();
      test_random_traffic();
      repeat (8) @(posedge clock);
      $display("Rendered %0d characters: %0d rectangles and %0d status transactions checked",
               chars_sent, rects_seen, status_seen);
      $display("Status mix: %0d not ready, %0d parameter errors, %0d mismatches",
               not_ready_seen, param_errors_seen, mismatches);
      if (mismatches == 0 && due_items.size() == 0) begin
         $display("PASS scaled_glyph_renderer");
      end else begin
         $display("FAIL scaled_glyph_renderer");
      end
      $finish;
   end

endmodule
